### src/lfr_pkg.sv
// Shared types and constants for the LIN frame receiver.
// Used by lfr_pid_match and lin_frame_receiver; no dependencies.
package lfr_pkg;

  localparam int unsigned TABLE_ENTRIES     = 8;
  localparam int unsigned FRAME_BYTES       = 8;
  localparam int unsigned DEF_MAX_FILTERS   = 8;
  localparam int unsigned DEF_MAX_DATA_BYTES = 8;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned CFG_IDX_W         = 2;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_LINE   = 2'd1;
  localparam logic [1:0] REQ_ENABLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HI     = 2'd2;

  localparam logic [7:0] BREAK_BYTE = 8'h00;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [5:0] ID_DIAG_MREQ = 6'h3C;
  localparam logic [5:0] ID_DIAG_SRSP = 6'h3D;

  typedef struct packed {
    logic [2:0] rsvd;
    logic       enhanced_ok;
    logic       classic_ok;
    logic       header_only;
    logic [3:0] length;
    logic [5:0] id;
  } filter_entry_t;

  typedef filter_entry_t [TABLE_ENTRIES-1:0] filter_table_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]               frame_id;
    logic                     header_only;
    logic                     frame_class;
    logic [3:0]               data_length;
    logic [8*FRAME_BYTES-1:0] frame_data;
  } out_item_t;

  typedef struct packed {
    logic       parity_ok;
    logic       hit;
    logic [2:0] entry;
  } pid_match_t;

endpackage

### src/lfr_pid_match.sv
// PID parity check and first-match search of the filter table.
// Depends on lfr_pkg.
module lfr_pid_match #(
  parameter int unsigned MAX_FILTERS = lfr_pkg::DEF_MAX_FILTERS
) (
  input  logic [7:0]            pid_i,
  input  logic [3:0]            filter_count_i,
  input  lfr_pkg::filter_table_t table_i,
  output lfr_pkg::pid_match_t   match_o
);
  import lfr_pkg::*;

  logic [5:0] id;
  logic       p0;
  logic       p1;
  logic [MAX_FILTERS-1:0] hits;

  assign id = pid_i[5:0];
  assign p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
  assign p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);

  always_comb begin
    for (int i = 0; i < MAX_FILTERS; i++) begin
      hits[i] = (4'(i) < filter_count_i) && (table_i[i].id == id);
    end
  end

  always_comb begin
    match_o.parity_ok = (pid_i[6] == p0) && (pid_i[7] == p1);
    match_o.hit       = |hits;
    match_o.entry     = '0;
    for (int i = MAX_FILTERS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        match_o.entry = 3'(i);
      end
    end
  end

endmodule

### src/lin_frame_receiver.sv
// Slave-side LIN frame receiver: one item (byte, line event or enable) per clock cycle;
// a frame result is registered and appears on the output in the cycle after the item that
// completes it, and the next item is accepted in the same cycle unless a result is held
// waiting for out_ready_i. Depends on lfr_pkg and lfr_pid_match.
module lin_frame_receiver #(
  parameter int unsigned MAX_FILTERS    = lfr_pkg::DEF_MAX_FILTERS,
  parameter int unsigned MAX_DATA_BYTES = lfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lfr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lfr_pkg::out_item_t             out_item_o
);
  import lfr_pkg::*;

  localparam logic [2:0] PH_BREAK = 3'd0;
  localparam logic [2:0] PH_SYNC  = 3'd1;
  localparam logic [2:0] PH_PID   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  localparam int unsigned DIDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  function automatic logic [7:0] carry_add(logic [7:0] s, logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  logic [3:0]  filter_count_q;
  logic [63:0] table_lo_q;
  logic [63:0] table_hi_q;
  filter_table_t table_w;

  logic [2:0] phase_q, phase_d;
  logic       enabled_q, enabled_d;
  logic [3:0] byte_count_q, byte_count_d;
  logic [2:0] matched_q, matched_d;
  logic [7:0] classic_q, classic_d;
  logic [7:0] enhanced_q, enhanced_d;
  logic [7:0] frame_q [MAX_DATA_BYTES];
  logic       frame_we;

  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  res;
  logic       res_valid;
  logic       in_fire;

  pid_match_t    match;
  filter_entry_t hit_entry;
  filter_entry_t cur_entry;
  logic [3:0]    hit_len;
  logic [3:0]    cur_len;
  logic [8*FRAME_BYTES-1:0] frame_data;

  assign table_w = {table_hi_q, table_lo_q};

  lfr_pid_match #(
    .MAX_FILTERS(MAX_FILTERS)
  ) u_pid_match (
    .pid_i         (in_item_i.rx_byte),
    .filter_count_i(filter_count_q),
    .table_i       (table_w),
    .match_o       (match)
  );

  assign hit_entry = table_w[match.entry];
  assign cur_entry = table_w[matched_q];
  assign hit_len   = (hit_entry.length > MAX_LEN) ? MAX_LEN : hit_entry.length;
  assign cur_len   = (cur_entry.length > MAX_LEN) ? MAX_LEN : cur_entry.length;

  for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_data
    if (g < MAX_DATA_BYTES) begin : g_used
      assign frame_data[8*g +: 8] = (4'(g) < cur_len) ? frame_q[g] : 8'h00;
    end else begin : g_unused
      assign frame_data[8*g +: 8] = 8'h00;
    end
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    phase_d      = phase_q;
    enabled_d    = enabled_q;
    byte_count_d = byte_count_q;
    matched_d    = matched_q;
    classic_d    = classic_q;
    enhanced_d   = enhanced_q;
    frame_we     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    if (in_fire) begin
      unique case (in_item_i.req_type)
        REQ_LINE: phase_d = PH_BREAK;
        REQ_ENABLE: begin
          if (!enabled_q) begin
            enabled_d = 1'b1;
            phase_d   = PH_BREAK;
          end
        end
        REQ_BYTE: begin
          if (enabled_q) begin
            unique case (phase_q)
              PH_BREAK: begin
                if (in_item_i.rx_byte == BREAK_BYTE) begin
                  byte_count_d = '0;
                  phase_d      = PH_SYNC;
                end
              end
              PH_SYNC: phase_d = (in_item_i.rx_byte == SYNC_BYTE) ? PH_PID : PH_BREAK;
              PH_PID: begin
                if (!match.parity_ok || !match.hit) begin
                  phase_d = PH_BREAK;
                end else begin
                  matched_d = match.entry;
                  if (hit_entry.header_only) begin
                    enabled_d       = 1'b0;
                    phase_d         = PH_DONE;
                    res_valid       = 1'b1;
                    res.frame_id    = in_item_i.rx_byte[5:0];
                    res.header_only = 1'b1;
                  end else begin
                    byte_count_d = '0;
                    classic_d    = '0;
                    enhanced_d   = (in_item_i.rx_byte[5:0] == ID_DIAG_MREQ ||
                                    in_item_i.rx_byte[5:0] == ID_DIAG_SRSP) ?
                                   8'h00 : in_item_i.rx_byte;
                    phase_d      = (hit_len == 4'd0) ? PH_CHECK : PH_DATA;
                  end
                end
              end
              PH_DATA: begin
                if (byte_count_q < MAX_LEN) begin
                  frame_we   = 1'b1;
                  classic_d  = carry_add(classic_q, in_item_i.rx_byte);
                  enhanced_d = carry_add(enhanced_q, in_item_i.rx_byte);
                end
                byte_count_d = byte_count_q + 4'd1;
                if (byte_count_d >= cur_len) begin
                  phase_d = PH_CHECK;
                end
              end
              PH_CHECK: begin
                if (cur_entry.classic_ok && in_item_i.rx_byte == ~classic_q) begin
                  res_valid       = 1'b1;
                  res.frame_class = 1'b0;
                end else if (cur_entry.enhanced_ok && in_item_i.rx_byte == ~enhanced_q) begin
                  res_valid       = 1'b1;
                  res.frame_class = 1'b1;
                end
                if (res_valid) begin
                  enabled_d       = 1'b0;
                  phase_d         = PH_DONE;
                  res.frame_id    = cur_entry.id;
                  res.data_length = cur_len;
                  res.frame_data  = frame_data;
                end else begin
                  phase_d = PH_BREAK;
                end
              end
              default: phase_d = PH_BREAK;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_count_q <= 4'd1;
      table_lo_q     <= '0;
      table_hi_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_COUNT: filter_count_q <= cfg_wdata_i[3:0];
        CFG_TABLE_LO:     table_lo_q     <= cfg_wdata_i;
        CFG_TABLE_HI:     table_hi_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_BREAK;
      enabled_q    <= 1'b0;
      byte_count_q <= '0;
      matched_q    <= '0;
      classic_q    <= '0;
      enhanced_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      enabled_q    <= enabled_d;
      byte_count_q <= byte_count_d;
      matched_q    <= matched_d;
      classic_q    <= classic_d;
      enhanced_q   <= enhanced_d;
      if (in_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_q[byte_count_q[DIDX_W-1:0]] <= in_item_i.rx_byte;
    end
    if (in_fire && res_valid) begin
      out_item_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid) |=> (!enabled_q && phase_q == PH_DONE && out_valid_o))
    else $error("result did not disable reception");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.header_only) |->
      (!out_item_o.frame_class && out_item_o.data_length == 4'd0 &&
       out_item_o.frame_data == '0))
    else $error("header-only result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.data_length <= MAX_LEN))
    else $error("data length above limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

endmodule
